// ===== sv/bems_pkg.sv =====
// Shared types, constants and decode tables for the braille entry Morse sender.
// Used by bems_front, bems_back and braille_entry_morse_sender.
package bems_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
  localparam int POS_W       = $clog2(STORE_DEPTH);
  localparam int ADDR_W      = POS_W + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_J     = 8'h6A;
  localparam logic [5:0] CELL_LEAVE_NUM = 6'b000011;

  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_ENTER = 2'd1,
    FN_BACK  = 2'd2,
    FN_SEND  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_TICK     = 4'd0,
    ST_ADDED    = 4'd1,
    ST_NUM_LEFT = 4'd2,
    ST_INVALID  = 4'd3,
    ST_FULL     = 4'd4,
    ST_DELETED  = 4'd5,
    ST_EMPTY    = 4'd6,
    ST_SEND     = 4'd7,
    ST_SEND_IGN = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    CFG_LIMIT  = 3'd0,
    CFG_UNIT   = 3'd1,
    CFG_DASH   = 3'd2,
    CFG_LETTER = 3'd3,
    CFG_WORD   = 3'd4,
    CFG_OK     = 3'd5,
    CFG_ERR    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [8:0]  message_limit;
    logic [15:0] unit_ticks;
    logic [3:0]  dash_units;
    logic [3:0]  letter_gap_units;
    logic [3:0]  word_gap_units;
    logic [3:0]  ok_pulse_units;
    logic [3:0]  error_pulse_units;
  } cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] dots;
    logic [7:0] ch;
  } item_t;

  // Braille cell to character, zero for cells with no meaning.
  function automatic logic [7:0] cell_char(input logic [5:0] dots);
    logic [7:0] c;
    c = 8'h00;
    case (dots)
      6'h00: c = 8'h20;  6'h20: c = 8'h61;  6'h30: c = 8'h62;  6'h24: c = 8'h63;
      6'h26: c = 8'h64;  6'h22: c = 8'h65;  6'h34: c = 8'h66;  6'h36: c = 8'h67;
      6'h32: c = 8'h68;  6'h14: c = 8'h69;  6'h16: c = 8'h6A;  6'h28: c = 8'h6B;
      6'h38: c = 8'h6C;  6'h2C: c = 8'h6D;  6'h2E: c = 8'h6E;  6'h2A: c = 8'h6F;
      6'h3C: c = 8'h70;  6'h3E: c = 8'h71;  6'h3A: c = 8'h72;  6'h1C: c = 8'h73;
      6'h1E: c = 8'h74;  6'h29: c = 8'h75;  6'h39: c = 8'h76;  6'h17: c = 8'h77;
      6'h2D: c = 8'h78;  6'h2F: c = 8'h79;  6'h2B: c = 8'h7A;  6'h0F: c = 8'h23;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Morse elements, first element in bit 0 (dash = 1), marker bit above the last.
  function automatic logic [7:0] morse_pat(input logic [7:0] c);
    logic [7:0] p;
    p = 8'd0;
    case (c)
      8'h61: p = 8'd6;   8'h62: p = 8'd17;  8'h63: p = 8'd21;  8'h64: p = 8'd9;
      8'h65: p = 8'd2;   8'h66: p = 8'd20;  8'h67: p = 8'd11;  8'h68: p = 8'd16;
      8'h69: p = 8'd4;   8'h6A: p = 8'd30;  8'h6B: p = 8'd13;  8'h6C: p = 8'd18;
      8'h6D: p = 8'd7;   8'h6E: p = 8'd5;   8'h6F: p = 8'd15;  8'h70: p = 8'd22;
      8'h71: p = 8'd27;  8'h72: p = 8'd10;  8'h73: p = 8'd8;   8'h74: p = 8'd3;
      8'h75: p = 8'd12;  8'h76: p = 8'd24;  8'h77: p = 8'd14;  8'h78: p = 8'd25;
      8'h79: p = 8'd29;  8'h7A: p = 8'd19;
      8'h30: p = 8'd63;  8'h31: p = 8'd62;  8'h32: p = 8'd60;  8'h33: p = 8'd56;
      8'h34: p = 8'd48;  8'h35: p = 8'd32;  8'h36: p = 8'd33;  8'h37: p = 8'd35;
      8'h38: p = 8'd39;  8'h39: p = 8'd47;
      default: p = 8'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/bems_front.sv =====
// Front end: takes input beats, decodes the braille cell, queues the events.
// Depends on bems_pkg.
module bems_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_func,
  input  logic [5:0]      in_cell,
  output logic            q_valid,
  output bems_pkg::item_t q_item,
  input  logic            q_pop
);

  localparam int PTR_W = $clog2(bems_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(bems_pkg::QUEUE_DEPTH + 1);

  bems_pkg::item_t q_mem_r [bems_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign in_ready = (cnt_r != CNT_W'(bems_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Classify on the way in: keep the decoded character with the event.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{func: in_func, dots: in_cell,
                             ch: bems_pkg::cell_char(in_cell)};
    end
  end

endmodule

// ===== sv/bems_back.sv =====
// Back end: entry store, Morse player, feedback timer and result register.
// Depends on bems_pkg.
module bems_back (
  input  logic             clk,
  input  logic             rst_n,
  input  bems_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  bems_pkg::item_t  q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [3:0]       out_status,
  output logic             out_morse_on,
  output logic             out_feedback_on,
  output logic [8:0]       out_length,
  output logic             out_playing
);

  localparam int LW = bems_pkg::LEN_W;
  localparam int PW = bems_pkg::POS_W;
  localparam int AW = bems_pkg::ADDR_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_WR2    = 6'b000010,
    S_REF    = 6'b000100,
    S_ADV    = 6'b001000,
    S_ADV_CH = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_ON     = 5'b00010,
    PH_GAP    = 5'b00100,
    PH_LETTER = 5'b01000,
    PH_WORD   = 5'b10000
  } phase_t;

  logic [7:0] mem [2 * bems_pkg::STORE_DEPTH];
  logic [7:0] rd_data_r;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [7:0]    wd;

  state_t  st_r, st_nxt;
  phase_t  ph_r, ph_nxt;
  logic    bank_r, bank_nxt;
  logic [LW-1:0] len_r, len_nxt, plen_r, plen_nxt, pos_r, pos_nxt;
  logic [7:0]  last_r, last_nxt, pat_r, pat_nxt;
  logic [3:0]  uc_r, uc_nxt, fb_r, fb_nxt;
  logic [15:0] presc_r, presc_nxt;
  logic        play_r, play_nxt;
  logic [3:0]  status_r, status_nxt;

  logic          ov_r;
  logic [3:0]    o_status_r;
  logic          o_morse_r, o_fb_r, o_play_r;
  logic [LW-1:0] o_len_r;

  logic [LW-1:0] limit;
  logic [15:0]   period;
  logic [3:0]    dash;
  logic [7:0]    ch, dig, shifted, newpat;
  logic [LW-1:0] len_m1;
  logic          emit_ok;

  assign limit  = (cfg.message_limit > LW'(bems_pkg::STORE_DEPTH)) ?
                  LW'(bems_pkg::STORE_DEPTH) : cfg.message_limit;
  assign period = (cfg.unit_ticks == '0) ? 16'd1 : cfg.unit_ticks;
  assign dash   = (cfg.dash_units == '0) ? 4'd1 : cfg.dash_units;
  assign len_m1 = len_r - LW'(1);
  assign ch     = q_item.ch;
  assign shifted = pat_r >> 1;
  assign newpat  = bems_pkg::morse_pat(rd_data_r);
  assign emit_ok = !ov_r || out_ready;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  always_comb begin
    st_nxt = st_r;  ph_nxt = ph_r;  bank_nxt = bank_r;
    len_nxt = len_r;  plen_nxt = plen_r;  pos_nxt = pos_r;
    last_nxt = last_r;  pat_nxt = pat_r;  uc_nxt = uc_r;
    fb_nxt = fb_r;  presc_nxt = presc_r;  play_nxt = play_r;
    status_nxt = status_r;
    we = 1'b0;  wa = '0;  wd = '0;  ra = '0;
    q_pop = 1'b0;
    dig = ch;

    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          st_nxt = S_EMIT;
          case (bems_pkg::func_t'(q_item.func))
            bems_pkg::FN_TICK: begin
              status_nxt = bems_pkg::ST_TICK;
              if ({1'b0, presc_r} + 17'd1 >= {1'b0, period}) begin
                presc_nxt = '0;
                if (fb_r != '0) fb_nxt = fb_r - 4'd1;
                if (play_r) begin
                  if (uc_r > 4'd1) begin
                    uc_nxt = uc_r - 4'd1;
                  end else begin
                    uc_nxt = '0;
                    st_nxt = S_ADV;
                  end
                end
              end else begin
                presc_nxt = presc_r + 16'd1;
              end
            end
            bems_pkg::FN_ENTER: begin
              if (len_r >= limit) begin
                fb_nxt = cfg.error_pulse_units;
                status_nxt = bems_pkg::ST_FULL;
              end else if (last_r == bems_pkg::CH_HASH && len_r != '0) begin
                if (q_item.dots == bems_pkg::CELL_LEAVE_NUM) begin
                  len_nxt = len_m1;
                  fb_nxt = cfg.ok_pulse_units;
                  status_nxt = bems_pkg::ST_NUM_LEFT;
                  // Refresh the last character from the store.
                  if (len_m1 != '0) begin
                    ra = {bank_r, PW'(len_m1 - LW'(1))};
                    st_nxt = S_REF;
                  end else begin
                    last_nxt = '0;
                  end
                end else if ((ch >= bems_pkg::CH_A && ch <= bems_pkg::CH_I) ||
                             ch == bems_pkg::CH_J || ch == bems_pkg::CH_SPACE) begin
                  if (ch == bems_pkg::CH_J) dig = bems_pkg::CH_ZERO;
                  else if (ch != bems_pkg::CH_SPACE) dig = ch - bems_pkg::CH_A + bems_pkg::CH_ONE;
                  we = 1'b1;
                  wa = {bank_r, PW'(len_m1)};
                  wd = dig;
                  fb_nxt = cfg.ok_pulse_units;
                  status_nxt = bems_pkg::ST_ADDED;
                  st_nxt = S_WR2;
                end else begin
                  fb_nxt = cfg.error_pulse_units;
                  status_nxt = bems_pkg::ST_INVALID;
                end
              end else if (ch == '0) begin
                fb_nxt = cfg.error_pulse_units;
                status_nxt = bems_pkg::ST_INVALID;
              end else begin
                we = 1'b1;
                wa = {bank_r, PW'(len_r)};
                wd = ch;
                len_nxt = len_r + LW'(1);
                last_nxt = ch;
                fb_nxt = cfg.ok_pulse_units;
                status_nxt = bems_pkg::ST_ADDED;
              end
            end
            bems_pkg::FN_BACK: begin
              fb_nxt = cfg.ok_pulse_units;
              if (len_r != '0) begin
                len_nxt = len_m1;
                status_nxt = bems_pkg::ST_DELETED;
                if (len_m1 != '0) begin
                  ra = {bank_r, PW'(len_m1 - LW'(1))};
                  st_nxt = S_REF;
                end else begin
                  last_nxt = '0;
                end
              end else begin
                status_nxt = bems_pkg::ST_EMPTY;
              end
            end
            default: begin
              if (play_r) begin
                status_nxt = bems_pkg::ST_SEND_IGN;
              end else begin
                plen_nxt = len_r;
                pos_nxt  = '0;
                bank_nxt = !bank_r;
                len_nxt  = '0;
                last_nxt = '0;
                ph_nxt   = PH_IDLE;
                pat_nxt  = '0;
                play_nxt = 1'b1;
                status_nxt = bems_pkg::ST_SEND;
                st_nxt   = S_ADV;
              end
            end
          endcase
        end
      end
      // Second write of a digit: the number sign moves one place up.
      S_WR2: begin
        we = 1'b1;
        wa = {bank_r, PW'(len_r)};
        wd = bems_pkg::CH_HASH;
        len_nxt = len_r + LW'(1);
        last_nxt = bems_pkg::CH_HASH;
        st_nxt = S_EMIT;
      end
      S_REF: begin
        last_nxt = rd_data_r;
        st_nxt = S_EMIT;
      end
      // Advance the player one step a cycle until it settles on a timed phase.
      S_ADV: begin
        case (ph_r)
          PH_ON: begin
            ph_nxt = PH_GAP;
            uc_nxt = 4'd1;
            st_nxt = S_EMIT;
          end
          PH_GAP: begin
            pat_nxt = shifted;
            if (shifted > 8'd1) begin
              ph_nxt = PH_ON;
              uc_nxt = shifted[0] ? dash : 4'd1;
              st_nxt = S_EMIT;
            end else if (cfg.letter_gap_units != '0) begin
              ph_nxt = PH_LETTER;
              uc_nxt = cfg.letter_gap_units;
              st_nxt = S_EMIT;
            end else begin
              ph_nxt = PH_IDLE;
              uc_nxt = '0;
            end
          end
          PH_WORD: begin
            if (cfg.letter_gap_units != '0) begin
              ph_nxt = PH_LETTER;
              uc_nxt = cfg.letter_gap_units;
              st_nxt = S_EMIT;
            end else begin
              ph_nxt = PH_IDLE;
              uc_nxt = '0;
            end
          end
          PH_IDLE: begin
            if (pos_r >= plen_r) begin
              play_nxt = 1'b0;
              pat_nxt  = '0;
              uc_nxt   = '0;
              st_nxt   = S_EMIT;
            end else begin
              ra = {!bank_r, PW'(pos_r)};
              pos_nxt = pos_r + LW'(1);
              st_nxt = S_ADV_CH;
            end
          end
          default: begin
            ph_nxt = PH_IDLE;
          end
        endcase
      end
      S_ADV_CH: begin
        if (rd_data_r == bems_pkg::CH_SPACE) begin
          ph_nxt = PH_WORD;
          uc_nxt = cfg.word_gap_units;
          st_nxt = (cfg.word_gap_units != '0) ? S_EMIT : S_ADV;
        end else if (newpat > 8'd1) begin
          pat_nxt = newpat;
          ph_nxt  = PH_ON;
          uc_nxt  = newpat[0] ? dash : 4'd1;
          st_nxt  = S_EMIT;
        end else if (cfg.letter_gap_units != '0) begin
          ph_nxt = PH_LETTER;
          uc_nxt = cfg.letter_gap_units;
          st_nxt = S_EMIT;
        end else begin
          ph_nxt = PH_IDLE;
          uc_nxt = cfg.letter_gap_units;
          st_nxt = S_ADV;
        end
      end
      S_EMIT: begin
        if (emit_ok) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;  ph_r <= PH_IDLE;  bank_r <= 1'b0;
      len_r <= '0;  plen_r <= '0;  pos_r <= '0;  last_r <= '0;
      pat_r <= '0;  uc_r <= '0;  fb_r <= '0;  presc_r <= '0;
      play_r <= 1'b0;  status_r <= '0;  ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;  ph_r <= ph_nxt;  bank_r <= bank_nxt;
      len_r <= len_nxt;  plen_r <= plen_nxt;  pos_r <= pos_nxt;  last_r <= last_nxt;
      pat_r <= pat_nxt;  uc_r <= uc_nxt;  fb_r <= fb_nxt;  presc_r <= presc_nxt;
      play_r <= play_nxt;  status_r <= status_nxt;
      if (st_r == S_EMIT && emit_ok) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_EMIT && emit_ok) begin
      o_status_r <= status_r;
      o_morse_r  <= play_r && (ph_r == PH_ON);
      o_fb_r     <= (fb_r != '0);
      o_len_r    <= len_r;
      o_play_r   <= play_r;
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = o_status_r;
  assign out_morse_on    = o_morse_r;
  assign out_feedback_on = o_fb_r;
  assign out_length      = o_len_r;
  assign out_playing     = o_play_r;

endmodule

// ===== sv/braille_entry_morse_sender.sv =====
// Top level of the braille entry Morse sender: configuration registers and stream ports.
// Depends on bems_pkg, bems_front and bems_back.
//
// Each input beat is one event (tick, enter cell, backspace, send) and yields exactly
// one result beat. A front queue of two events decouples the input from the back end,
// which owns the 512-byte two-bank character store, the Morse player and the feedback
// timer. The back end pops an event only when idle and returns to idle once the result
// is in the output register. A tick that moves no player, a plain enter, an invalid or
// full enter, an ignored send, and a backspace or number-mode exit that leaves the
// store empty go straight to the result state. A number-mode digit adds a second store
// write, and a backspace or number-mode exit that leaves characters behind adds a store
// read of the new last character. A send, or a tick on a unit boundary that moves the
// player, adds player steps, one a cycle: one to close an element or a gap, two for each
// character read from the store, one more for a space when the word gap is zero, and one
// to stop at the end of the message; with zero gaps the steps grow with the number of
// spaces and signs skipped in a row. A result that waits on out_tready stalls the back
// end, and the queue fills and drops in_tready. Configuration writes complete at once.
module braille_entry_morse_sender (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [5:0] cell_req, [7:6] zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] morse_on, [1] feedback_on, [10:2] message_length,
                                  // [11] playing, [15:12] zero
  output logic [3:0]  out_tuser,  // [3:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  bems_pkg::cfg_t  cfg_r;
  bems_pkg::item_t q_item;
  logic q_valid, q_pop;
  logic morse_on, feedback_on, playing;
  logic [8:0] msg_len;

  assign cfg_ready = 1'b1;

  // Hold the registers; accept a write on every beat, drop unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.message_limit     <= 9'd140;
      cfg_r.unit_ticks        <= 16'd100;
      cfg_r.dash_units        <= 4'd3;
      cfg_r.letter_gap_units  <= 4'd2;
      cfg_r.word_gap_units    <= 4'd2;
      cfg_r.ok_pulse_units    <= 4'd1;
      cfg_r.error_pulse_units <= 4'd5;
    end else if (cfg_valid) begin
      case (bems_pkg::cfg_idx_t'(cfg_index))
        bems_pkg::CFG_LIMIT:  cfg_r.message_limit     <= cfg_data[8:0];
        bems_pkg::CFG_UNIT:   cfg_r.unit_ticks        <= cfg_data;
        bems_pkg::CFG_DASH:   cfg_r.dash_units        <= cfg_data[3:0];
        bems_pkg::CFG_LETTER: cfg_r.letter_gap_units  <= cfg_data[3:0];
        bems_pkg::CFG_WORD:   cfg_r.word_gap_units    <= cfg_data[3:0];
        bems_pkg::CFG_OK:     cfg_r.ok_pulse_units    <= cfg_data[3:0];
        bems_pkg::CFG_ERR:    cfg_r.error_pulse_units <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  bems_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_func  (in_tuser),
    .in_cell  (in_tdata[5:0]),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  bems_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_status      (out_tuser),
    .out_morse_on    (morse_on),
    .out_feedback_on (feedback_on),
    .out_length      (msg_len),
    .out_playing     (playing)
  );

  assign out_tdata = {4'd0, playing, msg_len, feedback_on, morse_on};

endmodule

// ===== tb/sv/braille_entry_morse_sender_test.sv =====
// Self-checking testbench for braille_entry_morse_sender: streams events and compares results.
// Depends on bems_pkg and the braille_entry_morse_sender RTL.
`timescale 1ns / 1ps

module braille_entry_morse_sender_test;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DEPTH       = bems_pkg::STORE_DEPTH;

  typedef enum int {KEY_IDLE, KEY_ON, KEY_GAP, KEY_LETTER, KEY_WORD} key_phase_t;

  typedef struct {
    bems_pkg::func_t func;
    logic [5:0]      dots;
  } event_t;

  typedef struct {
    bems_pkg::status_t status;
    logic              morse_on;
    logic              feedback_on;
    logic [8:0]        length;
    logic              playing;
  } keyer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;    // [5:0] cell_req, [7:6] zero
  logic [1:0]  in_tuser = 2'd0;    // [1:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [0] morse_on, [1] feedback_on, [10:2] length, [11] playing
  logic [3:0]  out_tuser;          // [3:0] status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;

  braille_entry_morse_sender dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Keyer predictor state: its own copy of the registers and the entry/player.
  // ---------------------------------------------------------------------------
  int unsigned lim_r, unit_r, dash_r, lgap_r, wgap_r, okp_r, errp_r;
  logic [7:0]  char_mem [2*DEPTH];
  int unsigned bank, entry_len, last_ch, play_len, play_pos;
  int unsigned elem_bits, units_left, prescale, fb_units;
  key_phase_t  key_phase;
  bit          keying;

  string letter_morse [26] = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
    ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-", "..-",
    "...-", ".--", "-..-", "-.--", "--.."};
  string digit_morse [10] = '{"-----", ".----", "..---", "...--", "....-", ".....", "-....",
    "--...", "---..", "----."};

  // Letter cells plus blank; used to build well-formed words.
  logic [5:0] word_cells [27] = '{6'h00, 6'h20, 6'h30, 6'h24, 6'h26, 6'h22, 6'h34, 6'h36,
    6'h32, 6'h14, 6'h16, 6'h28, 6'h38, 6'h2C, 6'h2E, 6'h2A, 6'h3C, 6'h3E, 6'h3A, 6'h1C,
    6'h1E, 6'h29, 6'h39, 6'h17, 6'h2D, 6'h2F, 6'h2B};

  function automatic int unsigned braille_char(logic [5:0] dots);
    case (dots)
      6'h00: return " ";
      6'h0F: return "#";
      default: begin
        for (int i = 1; i < 27; i++)
          if (word_cells[i] == dots) return "a" + i - 1;
        return 0;
      end
    endcase
  endfunction

  function automatic int unsigned mem_addr(int unsigned b, int unsigned pos);
    return ((b & 1) * DEPTH + pos) % (2 * DEPTH);
  endfunction

  function automatic int unsigned element_len();
    if (elem_bits & 1) return (dash_r != 0) ? dash_r : 1;
    return 1;
  endfunction

  function automatic int unsigned morse_bits(int unsigned c);
    string s;
    int unsigned p;
    p = 1;
    if (c >= "a" && c <= "z") s = letter_morse[c - "a"];
    else if (c >= "0" && c <= "9") s = digit_morse[c - "0"];
    else return 0;
    for (int i = s.len() - 1; i >= 0; i--)
      p = (p << 1) | ((s[i] == "-") ? 1 : 0);
    return p;
  endfunction

  // Walk the player until it lands in a phase that lasts at least one unit or the message ends.
  function automatic void key_step();
    bit stop;
    int unsigned c, p;
    stop = 0;
    while (!stop) begin
      case (key_phase)
        KEY_ON: begin
          key_phase = KEY_GAP;
          units_left = 1;
          stop = 1;
        end
        KEY_GAP: begin
          elem_bits = elem_bits >> 1;
          if (elem_bits > 1) begin
            key_phase = KEY_ON;
            units_left = element_len();
            stop = 1;
          end else begin
            key_phase = KEY_LETTER;
            units_left = lgap_r;
            if (units_left != 0) stop = 1;
            else key_phase = KEY_IDLE;
          end
        end
        KEY_WORD: begin
          key_phase = KEY_LETTER;
          units_left = lgap_r;
          if (units_left != 0) stop = 1;
          else key_phase = KEY_IDLE;
        end
        KEY_IDLE: begin
          if (play_pos >= play_len) begin
            keying = 0;
            elem_bits = 0;
            units_left = 0;
            stop = 1;
          end else begin
            c = char_mem[mem_addr(bank ^ 1, play_pos)];
            play_pos++;
            if (c == " ") begin
              key_phase = KEY_WORD;
              units_left = wgap_r;
              if (units_left != 0) stop = 1;
            end else begin
              p = morse_bits(c);
              if (p > 1) begin
                elem_bits = p;
                key_phase = KEY_ON;
                units_left = element_len();
                stop = 1;
              end else begin
                key_phase = KEY_LETTER;
                units_left = lgap_r;
                if (units_left != 0) stop = 1;
                else key_phase = KEY_IDLE;
              end
            end
          end
        end
        default: key_phase = KEY_IDLE;
      endcase
    end
  endfunction

  function automatic void refresh_last();
    last_ch = (entry_len != 0) ? char_mem[mem_addr(bank, entry_len - 1)] : 0;
  endfunction

  function automatic void append_ch(int unsigned c);
    char_mem[mem_addr(bank, entry_len)] = c[7:0];
    entry_len++;
    last_ch = c;
  endfunction

  function automatic bems_pkg::status_t enter_cell(logic [5:0] dots);
    int unsigned c, lim;
    bit ok;
    c = braille_char(dots);
    ok = (c != 0);
    lim = (lim_r < DEPTH) ? lim_r : DEPTH;
    // Full check wins over everything, leaving number mode included.
    if (entry_len >= lim) begin
      fb_units = errp_r;
      return bems_pkg::ST_FULL;
    end
    if (last_ch == "#" && entry_len > 0) begin
      if (dots == bems_pkg::CELL_LEAVE_NUM) begin
        entry_len--;
        refresh_last();
        fb_units = okp_r;
        return bems_pkg::ST_NUM_LEFT;
      end
      if (c >= "a" && c <= "i") c = "1" + (c - "a");
      else if (c == "j") c = "0";
      else if (c != " ") ok = 0;
      if (!ok) begin
        fb_units = errp_r;
        return bems_pkg::ST_INVALID;
      end
      // Digit replaces the sign; the sign moves up behind it.
      char_mem[mem_addr(bank, entry_len - 1)] = c[7:0];
      append_ch("#");
    end else begin
      if (!ok) begin
        fb_units = errp_r;
        return bems_pkg::ST_INVALID;
      end
      append_ch(c);
    end
    fb_units = okp_r;
    return bems_pkg::ST_ADDED;
  endfunction

  function automatic keyer_result_t predict_keyer(event_t ev);
    keyer_result_t r;
    int unsigned period;
    bems_pkg::status_t st;
    st = bems_pkg::ST_TICK;
    period = (unit_r != 0) ? unit_r : 1;
    case (ev.func)
      bems_pkg::FN_TICK: begin
        if (prescale + 1 >= period) begin
          prescale = 0;
          if (fb_units != 0) fb_units--;
          if (keying) begin
            if (units_left > 1) units_left--;
            else begin
              units_left = 0;
              key_step();
            end
          end
        end else prescale++;
      end
      bems_pkg::FN_ENTER: st = enter_cell(ev.dots);
      bems_pkg::FN_BACK: begin
        if (entry_len > 0) begin
          entry_len--;
          refresh_last();
          st = bems_pkg::ST_DELETED;
        end else st = bems_pkg::ST_EMPTY;
        fb_units = okp_r;
      end
      default: begin
        if (keying) st = bems_pkg::ST_SEND_IGN;
        else begin
          play_len = entry_len;
          play_pos = 0;
          bank ^= 1;
          entry_len = 0;
          last_ch = 0;
          key_phase = KEY_IDLE;
          elem_bits = 0;
          keying = 1;
          key_step();
          st = bems_pkg::ST_SEND;
        end
      end
    endcase
    r.status = st;
    r.morse_on = keying && key_phase == KEY_ON;
    r.feedback_on = fb_units != 0;
    r.length = entry_len[8:0];
    r.playing = keying;
    return r;
  endfunction

  function automatic void apply_reg(bems_pkg::cfg_idx_t idx, logic [15:0] v);
    case (idx)
      bems_pkg::CFG_LIMIT:  lim_r  = v[8:0];
      bems_pkg::CFG_UNIT:   unit_r = v;
      bems_pkg::CFG_DASH:   dash_r = v[3:0];
      bems_pkg::CFG_LETTER: lgap_r = v[3:0];
      bems_pkg::CFG_WORD:   wgap_r = v[3:0];
      bems_pkg::CFG_OK:     okp_r  = v[3:0];
      bems_pkg::CFG_ERR:    errp_r = v[3:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping shared by driver, monitor and sequencer.
  // ---------------------------------------------------------------------------
  event_t        pending_events [$];
  keyer_result_t expected_results [$];
  int unsigned   sent_beats = 0, in_beats = 0, out_beats = 0, cfg_beats = 0;
  int unsigned   errors = 0, cycles = 0;
  bit            hold_input = 0;

  // Input driver: hold a beat until taken, then wait the drawn gap before the next.
  int unsigned in_gap = 0;
  always @(negedge clk) begin
    event_t ev;
    if (!rst_n || (in_tvalid && in_beats != sent_beats)) begin
      // hold: either in reset or the current beat is still waiting
    end else if (in_gap != 0) begin
      in_gap--;
      in_tvalid <= 1'b0;
    end else if (!hold_input && pending_events.size() != 0) begin
      ev = pending_events.pop_front();
      in_tdata <= {2'b00, ev.dots};
      in_tuser <= ev.func;
      in_tvalid <= 1'b1;
      sent_beats++;
      // every fourth stretch of 64 beats runs with no gaps
      in_gap = ((sent_beats / 64) % 4 == 3) ? 0 : $urandom_range(0, 17);
    end else in_tvalid <= 1'b0;
  end

  // Result receiver: after each beat, stall for a drawn number of cycles.
  int unsigned out_seen = 0, out_stall = 0;
  always @(negedge clk) begin
    if (out_seen != out_beats) begin
      out_seen = out_beats;
      out_stall = ((out_beats / 80) % 4 == 2) ? 0 : $urandom_range(0, 17);
    end
    out_tready <= rst_n && out_stall == 0;
    if (out_stall != 0) out_stall--;
  end

  // Monitor: apply register writes, predict accepted events, check results.
  always @(posedge clk) begin
    event_t ev;
    keyer_result_t want, got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("braille_entry_morse_sender_test: FAIL");
      $finish;
    end else if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(bems_pkg::cfg_idx_t'(cfg_index), cfg_data);
        cfg_beats++;
      end
      if (in_tvalid && in_tready) begin
        ev.func = bems_pkg::func_t'(in_tuser);
        ev.dots = in_tdata[5:0];
        expected_results.push_back(predict_keyer(ev));
        in_beats++;
      end
      if (out_tvalid && out_tready) begin
        out_beats++;
        got.status = bems_pkg::status_t'(out_tuser);
        got.morse_on = out_tdata[0];
        got.feedback_on = out_tdata[1];
        got.length = out_tdata[10:2];
        got.playing = out_tdata[11];
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: status %0d", $time, got.status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.morse_on !== want.morse_on) begin
            $display("%0t: morse_on expected %0b actual %0b", $time, want.morse_on,
                     got.morse_on);
            errors++;
          end
          if (got.feedback_on !== want.feedback_on) begin
            $display("%0t: feedback_on expected %0b actual %0b", $time, want.feedback_on,
                     got.feedback_on);
            errors++;
          end
          if (got.length !== want.length) begin
            $display("%0t: message_length expected %0d actual %0d", $time, want.length,
                     got.length);
            errors++;
          end
          if (got.playing !== want.playing) begin
            $display("%0t: playing expected %0b actual %0b", $time, want.playing,
                     got.playing);
            errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers.
  // ---------------------------------------------------------------------------
  task automatic push_event(bems_pkg::func_t f, logic [5:0] dots);
    event_t ev;
    ev.func = f;
    ev.dots = dots;
    pending_events.push_back(ev);
  endtask

  // Drain: nothing queued, nothing in flight, every result back.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(bems_pkg::cfg_idx_t idx, logic [15:0] v);
    int unsigned seen;
    seen = cfg_beats;
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (cfg_beats == seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_keyer(logic [15:0] lim, logic [15:0] unit, logic [15:0] dash,
                           logic [15:0] lgap, logic [15:0] wgap, logic [15:0] okp,
                           logic [15:0] errp);
    wait_quiet();
    write_reg(bems_pkg::CFG_LIMIT, lim);
    write_reg(bems_pkg::CFG_UNIT, unit);
    write_reg(bems_pkg::CFG_DASH, dash);
    write_reg(bems_pkg::CFG_LETTER, lgap);
    write_reg(bems_pkg::CFG_WORD, wgap);
    write_reg(bems_pkg::CFG_OK, okp);
    write_reg(bems_pkg::CFG_ERR, errp);
  endtask

  // Random traffic: mostly ticks and well-formed words and numbers, some noise.
  task automatic random_events(int n);
    int count, w, k;
    count = 0;
    while (count < n) begin
      w = $urandom_range(0, 99);
      if (w < 45) begin
        push_event(bems_pkg::FN_TICK, 6'($urandom));
        count++;
      end else if (w < 72) begin
        push_event(bems_pkg::FN_ENTER, word_cells[$urandom_range(0, 26)]);
        count++;
      end else if (w < 80) begin
        // number sign, a few digits or blanks, maybe leave number mode
        push_event(bems_pkg::FN_ENTER, 6'h0F);
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++)
          push_event(bems_pkg::FN_ENTER, word_cells[$urandom_range(0, 10)]);
        if ($urandom_range(0, 1)) push_event(bems_pkg::FN_ENTER, bems_pkg::CELL_LEAVE_NUM);
        count += k + 2;
      end else if (w < 86) begin
        push_event(bems_pkg::FN_ENTER, 6'($urandom));
        count++;
      end else if (w < 93) begin
        push_event(bems_pkg::FN_BACK, 6'($urandom));
        count++;
      end else begin
        push_event(bems_pkg::FN_SEND, 6'($urandom));
        count++;
      end
    end
  endtask

  initial begin
    lim_r = 140; unit_r = 100; dash_r = 3; lgap_r = 2; wgap_r = 2; okp_r = 1; errp_r = 5;
    bank = 0; entry_len = 0; last_ch = 0; play_len = 0; play_pos = 0;
    elem_bits = 0; units_left = 0; prescale = 0; fb_units = 0;
    key_phase = KEY_IDLE; keying = 0;
    foreach (char_mem[i]) char_mem[i] = 8'h00;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: fast units so the player moves within a few dozen ticks.
    set_keyer(140, 1, 3, 2, 2, 1, 5);
    push_event(bems_pkg::FN_SEND, 6'h00);          // empty send swaps banks, stays idle
    push_event(bems_pkg::FN_BACK, 6'h3F);          // backspace on empty
    push_event(bems_pkg::FN_ENTER, 6'h20);         // a
    push_event(bems_pkg::FN_ENTER, 6'h00);         // blank
    push_event(bems_pkg::FN_ENTER, 6'h2B);         // z
    push_event(bems_pkg::FN_ENTER, 6'h3F);         // invalid cell
    push_event(bems_pkg::FN_ENTER, bems_pkg::CELL_LEAVE_NUM); // leave cell outside number mode
    push_event(bems_pkg::FN_ENTER, 6'h0F);         // number sign
    push_event(bems_pkg::FN_ENTER, 6'h20);         // digit one
    push_event(bems_pkg::FN_ENTER, 6'h16);         // digit zero
    push_event(bems_pkg::FN_ENTER, 6'h00);         // blank inside number mode
    push_event(bems_pkg::FN_ENTER, 6'h28);         // letter k is no digit
    push_event(bems_pkg::FN_ENTER, 6'h0F);         // sign inside number mode
    push_event(bems_pkg::FN_ENTER, bems_pkg::CELL_LEAVE_NUM);
    push_event(bems_pkg::FN_BACK, 6'h00);
    push_event(bems_pkg::FN_SEND, 6'h00);
    push_event(bems_pkg::FN_SEND, 6'h00);          // ignored while keying
    for (int i = 0; i < 8; i++) push_event(bems_pkg::FN_TICK, 6'h00);
    random_events(280);

    // Pressure: once traffic is flowing, pause until every result is back, then resume.
    wait (pending_events.size() < 150);
    hold_input = 1;
    do @(negedge clk);
    while (in_tvalid || expected_results.size() != 0);
    hold_input = 0;

    // Zero settings: limit 1, zero unit, dash, gaps and pulses.
    set_keyer(1, 0, 0, 0, 0, 0, 0);
    random_events(180);

    // Largest store and longest units: fill to the limit, then key it.
    set_keyer(256, 2, 15, 15, 15, 15, 15);
    for (int i = 0; i < 258; i++)
      push_event(bems_pkg::FN_ENTER, word_cells[$urandom_range(1, 26)]);
    push_event(bems_pkg::FN_BACK, 6'h00);
    push_event(bems_pkg::FN_ENTER, 6'h0F);
    push_event(bems_pkg::FN_ENTER, bems_pkg::CELL_LEAVE_NUM);   // full store wins
    push_event(bems_pkg::FN_SEND, 6'h00);
    random_events(120);

    // Zero limit and slowest prescaler.
    set_keyer(0, 16'hFFFF, 1, 0, 15, 1, 1);
    random_events(80);

    // Limit above the store depth, short units.
    set_keyer(511, 3, 2, 0, 1, 2, 1);
    random_events(230);

    // Small store, fast keying.
    set_keyer(20, 1, 3, 1, 1, 1, 3);
    random_events(170);

    wait_quiet();
    repeat (600) @(negedge clk);
    if (errors == 0) $display("braille_entry_morse_sender_test: PASS");
    else $display("braille_entry_morse_sender_test: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bems_pkg.sv
sv/bems_front.sv
sv/bems_back.sv
sv/braille_entry_morse_sender.sv
tb/sv/braille_entry_morse_sender_test.sv
